// ----- hw/rtl/ppmd_pkg.sv -----
// shared types, constants and microcode encoding for the pid position motor drive
`default_nettype none

package ppmd_pkg;

    // default sizes of the position and integral datapaths
    localparam int POSITION_WIDTH_DEF = 24;
    localparam int INTEGRAL_WIDTH_DEF = 40;

    // fixed field and datapath widths
    localparam int GAIN_W    = 16;
    localparam int DRIVE_W   = 32;
    localparam int PWM_W     = 8;
    localparam int ACC_W     = 53;   // inner sum 256*e + ki*I + kd*D
    localparam int MAG_W     = 51;   // multiplicand magnitude, clamped to 2^50 (2^47 for the sum)
    localparam int MUL_SPLIT = 26;   // low chunk width of the shared multiplier
    localparam int PROD_W    = 67;   // MAG_W + GAIN_W
    localparam int OUT_W     = 48;   // result tdata, 45 bits padded to bytes
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W    = 5;
    localparam int STEPS     = 20;

    // register reset values and the full pwm duty
    localparam logic [GAIN_W-1:0] KP_RST      = 16'd256;
    localparam logic [GAIN_W-1:0] TOL_RST     = 16'd10;
    localparam logic [PWM_W-1:0]  SETTLE_RST  = 8'd55;
    localparam logic [GAIN_W-1:0] WINDUP_RST  = 16'd500;
    localparam logic [PWM_W-1:0]  PWM_FULL    = 8'd255;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KI     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDUP = 3'd6;

    // microprogram entry points
    localparam logic [STEP_W-1:0] STEP_TICK   = 5'd0;
    localparam logic [STEP_W-1:0] STEP_SETTLE = 5'd16;
    localparam logic [STEP_W-1:0] STEP_ESTOP  = 5'd17;
    localparam logic [STEP_W-1:0] STEP_START  = 5'd18;
    localparam logic [STEP_W-1:0] STEP_IDLE   = 5'd19;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_WINDOW,
        OP_INTEG,
        OP_LOAD_I,
        OP_LOAD_D,
        OP_LOAD_V,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_ACC,
        OP_DRIVE,
        OP_SETTLE,
        OP_ESTOP,
        OP_START,
        OP_IDLE
    } t_op;

    // branch conditions
    typedef enum logic [1:0] {
        C_NEVER,
        C_SETTLE,
        C_ESTOP
    } t_cond;

    // result status codes
    typedef enum logic [2:0] {
        ST_DRIVING,
        ST_SETTLED,
        ST_EMERGENCY,
        ST_IDLE,
        ST_STARTED
    } t_status;

    // one control word of the microprogram
    typedef struct packed {
        t_op               op;
        t_cond             cond;
        logic [STEP_W-1:0] target;
        logic              fin;
    } t_cword;

    // datapath flags seen by the sequencer
    typedef struct packed {
        logic settle;
        logic estop;
    } t_seq_flags;

endpackage

`default_nettype wire

// ----- hw/rtl/ppmd_seq.sv -----
// microcode sequencer: step counter, program rom and conditional jumps
`default_nettype none

module ppmd_seq
    import ppmd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [STEP_W-1:0] i_entry,
    input  logic              i_advance,
    input  t_seq_flags        i_flags,
    output t_cword            o_cword,
    output logic              o_busy
);

    // program: tick body, then the single-step result routines
    localparam t_cword PROGRAM [STEPS] = '{
        '{OP_WINDOW, C_NEVER,  STEP_TICK,   1'b0},  // window check, error
        '{OP_NOP,    C_SETTLE, STEP_SETTLE, 1'b0},
        '{OP_NOP,    C_ESTOP,  STEP_ESTOP,  1'b0},
        '{OP_INTEG,  C_NEVER,  STEP_TICK,   1'b0},  // integral, derivative
        '{OP_LOAD_I, C_NEVER,  STEP_TICK,   1'b0},
        '{OP_MUL_LO, C_NEVER,  STEP_TICK,   1'b0},
        '{OP_MUL_HI, C_NEVER,  STEP_TICK,   1'b0},
        '{OP_ACC,    C_NEVER,  STEP_TICK,   1'b0},
        '{OP_LOAD_D, C_NEVER,  STEP_TICK,   1'b0},
        '{OP_MUL_LO, C_NEVER,  STEP_TICK,   1'b0},
        '{OP_MUL_HI, C_NEVER,  STEP_TICK,   1'b0},
        '{OP_ACC,    C_NEVER,  STEP_TICK,   1'b0},
        '{OP_LOAD_V, C_NEVER,  STEP_TICK,   1'b0},
        '{OP_MUL_LO, C_NEVER,  STEP_TICK,   1'b0},
        '{OP_MUL_HI, C_NEVER,  STEP_TICK,   1'b0},
        '{OP_DRIVE,  C_NEVER,  STEP_TICK,   1'b1},
        '{OP_SETTLE, C_NEVER,  STEP_TICK,   1'b1},
        '{OP_ESTOP,  C_NEVER,  STEP_TICK,   1'b1},
        '{OP_START,  C_NEVER,  STEP_TICK,   1'b1},
        '{OP_IDLE,   C_NEVER,  STEP_TICK,   1'b1}
    };

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic              take_jump;

    assign o_cword = PROGRAM[r_step];
    assign o_busy  = r_busy;

    // branch condition select
    always_comb begin
        case (o_cword.cond)
            C_SETTLE: take_jump = i_flags.settle;
            C_ESTOP:  take_jump = i_flags.estop;
            default:  take_jump = 1'b0;
        endcase
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= STEP_TICK;
        end else if (!r_busy) begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= i_entry;
            end
        end else if (i_advance) begin
            if (o_cword.fin) begin
                r_busy <= 1'b0;
            end else if (take_jump) begin
                r_step <= o_cword.target;
            end else begin
                r_step <= r_step + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/pid_position_motor_drive.sv -----
// pid position controller with anti-windup: datapath, registers and stream ports
//
// usage: write the gains, target and limits on the configuration port while the
// block is idle. each input transaction carries a kind bit in s_axis_tuser
// (0 start a move, 1 control tick) and the encoder position and emergency level
// in s_axis_tdata. every input transaction yields exactly one result transaction
// on the m_axis side holding the direction pins, pwm duty, drive value u and
// status.
// a start or idle tick runs only its result step; a settled tick adds the
// window check and settle branch, an emergency tick also the estop branch,
// and a driving tick runs the tick body up to the drive step. the shared
// 26x16 multiplier, used twice per product for three products, makes that
// tick longest. one item is worked on at a time; s_axis_tready is high whenever
// the sequencer is free, also while a result waits in the output register.
// a stalled receiver holds the final microcode step until the output register
// drains; nothing is lost. reset restores the register defaults, disarms the
// move and clears error, integral and drive state; there is no clearing pass.
`default_nettype none

module pid_position_motor_drive
    import ppmd_pkg::*;
#(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
    parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF,
    localparam int CFG_W = (POSITION_WIDTH > GAIN_W) ? POSITION_WIDTH : GAIN_W,
    localparam int IN_W  = ((POSITION_WIDTH + 1 + 7) / 8) * 8
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_W-1:0]      s_axis_tdata,   // position, emergency_ok
    input  logic                 s_axis_tuser,   // action
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_W-1:0]     m_axis_tdata    // dir_a, dir_b, pwm_duty, drive_value, status
);

    localparam int P    = POSITION_WIDTH;
    localparam int I    = INTEGRAL_WIDTH;
    localparam int EW   = P + 1;
    localparam int DFW  = P + 2;
    localparam int WW   = ((P > 17) ? P : 17) + 1;
    localparam int SW   = ((I > EW) ? I : EW) + 1;
    localparam int SRCW = ((I > ACC_W) ? I : ACC_W) + 1;
    localparam int EAW  = (EW > GAIN_W) ? EW : GAIN_W;

    localparam logic signed [SW-1:0] IMAX = SW'((64'd1 << (I - 1)) - 64'd1);
    localparam logic signed [SW-1:0] IMIN = ~IMAX;
    localparam logic [SRCW-1:0] TERM_LIM = SRCW'(64'd1 << 50);
    localparam logic [SRCW-1:0] SUM_LIM  = SRCW'(64'd1 << 47);
    localparam logic [PROD_W-1:0] TERM_CAP = PROD_W'(64'd1 << 50);
    localparam logic [DRIVE_W-1:0] NEG_CAP = 32'h8000_0000;
    localparam logic [DRIVE_W-1:0] POS_CAP = 32'h7FFF_FFFF;
    localparam logic [DRIVE_W-1:0] PWM_MAXU = 32'd255;

    // configuration registers
    logic signed [P-1:0] r_target;
    logic [GAIN_W-1:0]   r_kp;
    logic [GAIN_W-1:0]   r_ki;
    logic [GAIN_W-1:0]   r_kd;
    logic [GAIN_W-1:0]   r_tol;
    logic [PWM_W-1:0]    r_slim;
    logic [GAIN_W-1:0]   r_wlim;

    // controller state
    logic                r_active;
    logic signed [EW-1:0]      r_prev_err;
    logic signed [I-1:0]       r_integ;
    logic signed [DRIVE_W-1:0] r_last_drive;

    // working registers
    logic signed [P-1:0]       r_pos;
    logic                      r_eok;
    logic                      r_settle;
    logic signed [EW-1:0]      r_err;
    logic signed [DFW-1:0]     r_diff;
    logic signed [ACC_W-1:0]   r_acc;
    logic [MAG_W-1:0]          r_mag;
    logic [GAIN_W-1:0]         r_k;
    logic                      r_neg;
    logic [PROD_W-1:0]         r_prod;

    // output register
    logic                      r_out_valid;
    logic                      r_dir_a;
    logic                      r_dir_b;
    logic [PWM_W-1:0]          r_pwm;
    logic signed [DRIVE_W-1:0] r_drive;
    t_status                   r_status;

    // sequencer link
    t_cword            cw;
    t_seq_flags        flags;
    logic              seq_busy;
    logic              seq_start;
    logic [STEP_W-1:0] seq_entry;
    logic              exec;

    assign s_axis_tready = !seq_busy;
    assign seq_start     = s_axis_tvalid && !seq_busy;
    assign seq_entry     = !s_axis_tuser ? STEP_START : (r_active ? STEP_TICK : STEP_IDLE);
    assign exec          = seq_busy && !(cw.fin && r_out_valid && !m_axis_tready);
    assign flags.settle  = r_settle;
    assign flags.estop   = !r_eok;

    ppmd_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (seq_start),
        .i_entry   (seq_entry),
        .i_advance (exec),
        .i_flags   (flags),
        .o_cword   (cw),
        .o_busy    (seq_busy)
    );

    // settled window and error
    logic signed [WW-1:0] tgt_w;
    logic signed [WW-1:0] pos_w;
    logic signed [WW-1:0] tol_w;
    logic signed [WW-1:0] win_lo;
    logic signed [WW-1:0] win_hi;
    logic                 in_win;
    logic                 last_le;
    logic signed [EW-1:0] err_new;

    always_comb begin
        tgt_w   = {{(WW-P){r_target[P-1]}}, r_target};
        pos_w   = {{(WW-P){r_pos[P-1]}}, r_pos};
        tol_w   = {{(WW-GAIN_W){1'b0}}, r_tol};
        win_lo  = tgt_w - tol_w;
        win_hi  = tgt_w + tol_w;
        in_win  = (pos_w >= win_lo) && (pos_w <= win_hi);
        last_le = r_last_drive <= $signed({{(DRIVE_W-PWM_W){1'b0}}, r_slim});
        err_new = {r_target[P-1], r_target} - {r_pos[P-1], r_pos};
    end

    // saturating integral and difference
    logic signed [SW-1:0]    sum_i;
    logic signed [I-1:0]     integ_sat;
    logic signed [DFW-1:0]   diff_new;
    logic signed [ACC_W-1:0] acc_init;

    always_comb begin
        sum_i = {{(SW-I){r_integ[I-1]}}, r_integ} + {{(SW-EW){r_err[EW-1]}}, r_err};
        if (sum_i > IMAX) begin
            integ_sat = IMAX[I-1:0];
        end else if (sum_i < IMIN) begin
            integ_sat = IMIN[I-1:0];
        end else begin
            integ_sat = sum_i[I-1:0];
        end
        diff_new = {r_err[EW-1], r_err} - {r_prev_err[EW-1], r_prev_err};
        acc_init = {{(ACC_W-EW-8){r_err[EW-1]}}, r_err, 8'd0};
    end

    // multiplicand load: magnitude, clamp, gain select
    logic signed [SRCW-1:0] src;
    logic [SRCW-1:0]        src_abs;
    logic [SRCW-1:0]        src_lim;
    logic [MAG_W-1:0]       mag_next;
    logic [GAIN_W-1:0]      k_next;

    always_comb begin
        case (cw.op)
            OP_LOAD_I: begin
                src    = {{(SRCW-I){r_integ[I-1]}}, r_integ};
                k_next = r_ki;
            end
            OP_LOAD_D: begin
                src    = {{(SRCW-DFW){r_diff[DFW-1]}}, r_diff};
                k_next = r_kd;
            end
            default: begin
                src    = {{(SRCW-ACC_W){r_acc[ACC_W-1]}}, r_acc};
                k_next = r_kp;
            end
        endcase
        src_abs  = src[SRCW-1] ? (~src + 1'b1) : src;
        src_lim  = (cw.op == OP_LOAD_V) ? SUM_LIM : TERM_LIM;
        mag_next = (src_abs > src_lim) ? src_lim[MAG_W-1:0] : src_abs[MAG_W-1:0];
    end

    // shared 26x16 multiplier, two chunks per product
    logic [MUL_SPLIT-1:0]        mul_a;
    logic [MUL_SPLIT+GAIN_W-1:0] mul_p;
    logic [PROD_W-1:0]           prod_hi;

    always_comb begin
        mul_a   = (cw.op == OP_MUL_HI) ? {1'b0, r_mag[MAG_W-1:MUL_SPLIT]}
                                       : r_mag[MUL_SPLIT-1:0];
        mul_p   = mul_a * r_k;
        prod_hi = r_prod + {mul_p[PROD_W-MUL_SPLIT-1:0], {MUL_SPLIT{1'b0}}};
    end

    // term accumulate with saturation at 2^50
    logic [MAG_W-1:0]        prod_term;
    logic signed [ACC_W-1:0] term_s;
    logic signed [ACC_W-1:0] acc_next;

    always_comb begin
        prod_term = (r_prod > TERM_CAP) ? TERM_CAP[MAG_W-1:0] : r_prod[MAG_W-1:0];
        term_s    = {{(ACC_W-MAG_W){1'b0}}, prod_term};
        acc_next  = r_neg ? (r_acc - term_s) : (r_acc + term_s);
    end

    // drive value, pwm and anti-windup
    logic [PROD_W-17:0]        pmag;
    logic [DRIVE_W-1:0]        umag;
    logic signed [DRIVE_W-1:0] u;
    logic                      u_big;
    logic [EW-1:0]             e_abs;
    logic                      windup;
    logic [PWM_W-1:0]          pwm_val;

    always_comb begin
        pmag = r_prod[PROD_W-1:16];
        if (r_neg) begin
            umag = (pmag > NEG_CAP) ? NEG_CAP : pmag[DRIVE_W-1:0];
        end else begin
            umag = (pmag > POS_CAP) ? POS_CAP : pmag[DRIVE_W-1:0];
        end
        u       = r_neg ? (32'd0 - umag) : umag;
        u_big   = umag > PWM_MAXU;
        e_abs   = r_err[EW-1] ? (~r_err + 1'b1) : r_err;
        windup  = u_big && (EAW'(e_abs) > EAW'(r_wlim));
        pwm_val = u_big ? PWM_FULL : umag[PWM_W-1:0];
    end

    // configuration, controller state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target     <= '0;
            r_kp         <= KP_RST;
            r_ki         <= '0;
            r_kd         <= '0;
            r_tol        <= TOL_RST;
            r_slim       <= SETTLE_RST;
            r_wlim       <= WINDUP_RST;
            r_active     <= 1'b0;
            r_prev_err   <= '0;
            r_integ      <= '0;
            r_last_drive <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_TARGET: r_target <= i_cfg_data[P-1:0];
                    CFG_KP:     r_kp     <= i_cfg_data[GAIN_W-1:0];
                    CFG_KI:     r_ki     <= i_cfg_data[GAIN_W-1:0];
                    CFG_KD:     r_kd     <= i_cfg_data[GAIN_W-1:0];
                    CFG_TOL:    r_tol    <= i_cfg_data[GAIN_W-1:0];
                    CFG_SETTLE: r_slim   <= i_cfg_data[PWM_W-1:0];
                    CFG_WINDUP: r_wlim   <= i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (exec) begin
                case (cw.op)
                    OP_START: begin
                        r_active     <= 1'b1;
                        r_prev_err   <= '0;
                        r_integ      <= '0;
                        r_last_drive <= '0;
                    end
                    OP_SETTLE, OP_ESTOP: r_active <= 1'b0;
                    OP_INTEG: begin
                        r_integ    <= integ_sat;
                        r_prev_err <= r_err;
                    end
                    OP_DRIVE: begin
                        r_last_drive <= u;
                        if (windup) begin
                            r_integ <= '0;
                        end
                    end
                    default: ;
                endcase
            end
            if (exec && cw.fin) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers and result payload
    always_ff @(posedge i_clk) begin
        if (seq_start) begin
            r_pos <= s_axis_tdata[P-1:0];
            r_eok <= s_axis_tdata[P];
        end
        if (exec) begin
            case (cw.op)
                OP_WINDOW: begin
                    r_settle <= in_win && last_le;
                    r_err    <= err_new;
                end
                OP_INTEG: begin
                    r_diff <= diff_new;
                    r_acc  <= acc_init;
                end
                OP_LOAD_I, OP_LOAD_D, OP_LOAD_V: begin
                    r_mag <= mag_next;
                    r_k   <= k_next;
                    r_neg <= src[SRCW-1];
                end
                OP_MUL_LO: r_prod <= PROD_W'(mul_p);
                OP_MUL_HI: r_prod <= prod_hi;
                OP_ACC:    r_acc  <= acc_next;
                default: ;
            endcase
        end
        if (exec && cw.fin) begin
            case (cw.op)
                OP_DRIVE: begin
                    r_dir_a  <= u[DRIVE_W-1];
                    r_dir_b  <= !u[DRIVE_W-1];
                    r_pwm    <= pwm_val;
                    r_drive  <= u;
                    r_status <= ST_DRIVING;
                end
                OP_SETTLE: begin
                    r_dir_a  <= 1'b0;
                    r_dir_b  <= 1'b0;
                    r_pwm    <= PWM_FULL;
                    r_drive  <= '0;
                    r_status <= ST_SETTLED;
                end
                OP_ESTOP: begin
                    r_dir_a  <= 1'b0;
                    r_dir_b  <= 1'b0;
                    r_pwm    <= PWM_FULL;
                    r_drive  <= '0;
                    r_status <= ST_EMERGENCY;
                end
                OP_START: begin
                    r_dir_a  <= 1'b0;
                    r_dir_b  <= 1'b0;
                    r_pwm    <= '0;
                    r_drive  <= '0;
                    r_status <= ST_STARTED;
                end
                default: begin
                    r_dir_a  <= 1'b0;
                    r_dir_b  <= 1'b0;
                    r_pwm    <= '0;
                    r_drive  <= '0;
                    r_status <= ST_IDLE;
                end
            endcase
        end
    end

    // result stream
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_status, r_drive, r_pwm, r_dir_b, r_dir_a};

endmodule

`default_nettype wire
